### rtl/core/bptc_pkg.sv
// ---------------------------------------------------------------------------
// Barometric compensation package
// Shared constants, register codes and word types for the compensation core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bptc_pkg;

   // Configuration port geometry: 64-bit registers at 8-byte spacing.
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;

   // Compensation constants.
   localparam int TEMP_OFFSET = 128000;
   localparam int PRESS_SCALE = 3125;
   localparam int PRESS_BASE  = 1048576;
   localparam int TERM_BIT    = 47;
   localparam int DIV_SHIFT   = 33;
   localparam int TEMP_ROUND  = 128;

   // Quotient width of the pressure divider.
   localparam int DIV_W = 64;

   // Register codes, index = paddr[4:3].
   typedef enum logic [1:0] {
      REG_TEMP_COEFFS = 2'd0,
      REG_PRESS_LOW   = 2'd1,
      REG_PRESS_HIGH  = 2'd2,
      REG_PRESS_NINTH = 2'd3
   } reg_index_type;

   // Temperature results that ride along with the pressure pipeline.
   typedef struct packed {
      logic signed [31:0] tf;
      logic signed [31:0] tc;
   } side_type;

   // Result word; the low 96 bits map straight onto rsp_tdata.
   typedef struct packed {
      logic        invalid;
      logic [31:0] pres;
      logic [31:0] tf;
      logic [31:0] tc;
   } out_word_type;

endpackage

`default_nettype wire

### rtl/core/bptc_temp.sv
// ---------------------------------------------------------------------------
// Temperature stages
// Five pipeline stages that form the fine temperature, the centidegree
// temperature and the pressure offset term x1 = tf - 128000.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bptc_temp (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  logic [19:0]         raw_t,
   input  logic [19:0]         raw_p,
   input  logic [15:0]         t1,
   input  logic signed [15:0]  t2,
   input  logic signed [15:0]  t3,
   output logic                out_valid,
   output bptc_pkg::side_type  out_side,
   output logic [25:0]         out_x1,
   output logic [19:0]         out_raw_p
);

   logic [4:0] v_ff;
   logic [4:0] v_in;

   logic signed [17:0] d1_ff, d1_in;
   logic signed [16:0] d2_ff, d2_in;
   logic [19:0]        p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic signed [33:0] m1_ff, m1_in;
   logic signed [33:0] sq_ff, sq_in;
   logic signed [22:0] v1_ff, v1_in;
   logic signed [37:0] m2_ff, m2_in;
   logic [24:0]        tf_ff, tf_in;
   logic [26:0]        t5_sum;
   logic [31:0]        tc_ff, tc_in;
   logic [25:0]        x1_ff, x1_in;
   logic [31:0]        tfo_ff;

   // Stage arithmetic.
   always_comb begin
      d1_in  = $signed({1'b0, raw_t[19:3]}) - $signed({1'b0, t1, 1'b0});
      d2_in  = $signed({1'b0, raw_t[19:4]}) - $signed({1'b0, t1});
      m1_in  = d1_ff * t2;
      sq_in  = d2_ff * d2_ff;
      v1_in  = m1_ff[33:11];
      m2_in  = $signed(sq_ff[33:12]) * t3;
      tf_in  = {{2{v1_ff[22]}}, v1_ff} + {m2_ff[37], m2_ff[37:14]};
      t5_sum = {tf_ff, 2'b00} + {{2{tf_ff[24]}}, tf_ff} + 27'(bptc_pkg::TEMP_ROUND);
      tc_in  = {{13{t5_sum[26]}}, t5_sum[26:8]};
      x1_in  = {tf_ff[24], tf_ff} - 26'(bptc_pkg::TEMP_OFFSET);
      v_in   = {v_ff[3:0], in_valid};
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   // Data registers.
   always_ff @(posedge clock) begin
      if (adv) begin
         d1_ff  <= d1_in;
         d2_ff  <= d2_in;
         p1_ff  <= raw_p;
         m1_ff  <= m1_in;
         sq_ff  <= sq_in;
         p2_ff  <= p1_ff;
         v1_ff  <= v1_in;
         m2_ff  <= m2_in;
         p3_ff  <= p2_ff;
         tf_ff  <= tf_in;
         p4_ff  <= p3_ff;
         tc_ff  <= tc_in;
         x1_ff  <= x1_in;
         tfo_ff <= {{7{tf_ff[24]}}, tf_ff};
         p5_ff  <= p4_ff;
      end
   end

   assign out_valid   = v_ff[4];
   assign out_side.tf = tfo_ff;
   assign out_side.tc = tc_ff;
   assign out_x1      = x1_ff;
   assign out_raw_p   = p5_ff;

endmodule

`default_nettype wire

### rtl/core/bptc_front.sv
// ---------------------------------------------------------------------------
// Pressure front stages
// Six pipeline stages that build the 64-bit wrapping numerator and the
// divisor of the pressure division.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bptc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  bptc_pkg::side_type  in_side,
   input  logic [25:0]         in_x1,
   input  logic [19:0]         in_raw_p,
   input  logic [15:0]         p1,
   input  logic signed [15:0]  p2,
   input  logic signed [15:0]  p3,
   input  logic signed [15:0]  p4,
   input  logic signed [15:0]  p5,
   input  logic signed [15:0]  p6,
   output logic                out_valid,
   output bptc_pkg::side_type  out_side,
   output logic [63:0]         out_num,
   output logic [30:0]         out_den
);

   logic [5:0] v_ff;
   logic [5:0] v_in;
   bptc_pkg::side_type side_ff [0:5];

   // Stage 1.
   logic signed [51:0] sq_ff, sq_in;
   logic signed [41:0] m5_ff, m5_in, m2_ff, m2_in;
   logic [20:0]        pn1_ff, pn_in, pn2_ff, pn3_ff;
   // Stage 2.
   logic signed [67:0] a6_full, a3_full;
   logic [63:0]        a6_ff, a3_ff, x2p_ff, x2p_in, m2s_ff, m2s_in;
   // Stage 3.
   logic [63:0]        x2_ff, x2_in, x1b_ff, x1b_in;
   // Stage 4.
   logic [63:0]        a_ff, a_in, nb_ff, nb_in;
   // Stage 5.
   logic [47:0]        alo_ff, alo_in;
   logic [31:0]        ahi_ff, ahi_in, nhi_ff, nhi_in;
   logic [43:0]        nlo_ff, nlo_in;
   // Stage 6.
   logic [63:0]        r1_in, num_ff, num_in;
   logic [30:0]        den_ff;

   // Stage arithmetic, products wrap to 64 bits.
   always_comb begin
      sq_in   = $signed(in_x1) * $signed(in_x1);
      m5_in   = $signed(in_x1) * p5;
      m2_in   = $signed(in_x1) * p2;
      pn_in   = 21'(bptc_pkg::PRESS_BASE) - {1'b0, in_raw_p};

      a6_full = sq_ff * p6;
      a3_full = sq_ff * p3;
      x2p_in  = ({{22{m5_ff[41]}}, m5_ff} << 17) + ({{48{p4[15]}}, p4} << 35);
      m2s_in  = {{22{m2_ff[41]}}, m2_ff} << 12;

      x2_in   = a6_ff + x2p_ff;
      x1b_in  = {{8{a3_ff[63]}}, a3_ff[63:8]} + m2s_ff;

      a_in    = x1b_ff + (64'd1 << bptc_pkg::TERM_BIT);
      nb_in   = ({43'd0, pn3_ff} << 31) - x2_ff;

      alo_in  = a_ff[31:0] * p1;
      ahi_in  = a_ff[63:32] * {16'd0, p1};
      nlo_in  = nb_ff[31:0] * 12'(bptc_pkg::PRESS_SCALE);
      nhi_in  = nb_ff[63:32] * 32'(bptc_pkg::PRESS_SCALE);

      r1_in   = {16'd0, alo_ff} + {ahi_ff, 32'd0};
      num_in  = {20'd0, nlo_ff} + {nhi_ff, 32'd0};
      v_in    = {v_ff[4:0], in_valid};
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   // Data registers.
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= in_side;
         for (int i = 1; i < 6; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         sq_ff  <= sq_in;
         m5_ff  <= m5_in;
         m2_ff  <= m2_in;
         pn1_ff <= pn_in;
         a6_ff  <= a6_full[63:0];
         a3_ff  <= a3_full[63:0];
         x2p_ff <= x2p_in;
         m2s_ff <= m2s_in;
         pn2_ff <= pn1_ff;
         x2_ff  <= x2_in;
         x1b_ff <= x1b_in;
         pn3_ff <= pn2_ff;
         a_ff   <= a_in;
         nb_ff  <= nb_in;
         alo_ff <= alo_in;
         ahi_ff <= ahi_in;
         nlo_ff <= nlo_in;
         nhi_ff <= nhi_in;
         den_ff <= r1_in[63:bptc_pkg::DIV_SHIFT];
         num_ff <= num_in;
      end
   end

   assign out_valid = v_ff[5];
   assign out_side  = side_ff[5];
   assign out_num   = num_ff;
   assign out_den   = den_ff;

endmodule

`default_nettype wire

### rtl/core/bptc_sdiv.sv
// ---------------------------------------------------------------------------
// Pipelined signed divider
// Sign strip, one restoring quotient bit per stage, then sign restore.
// A zero divisor is flagged; its quotient is not used.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bptc_sdiv (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  bptc_pkg::side_type  in_side,
   input  logic [63:0]         in_num,
   input  logic [30:0]         in_den,
   output logic                out_valid,
   output bptc_pkg::side_type  out_side,
   output logic                out_invalid,
   output logic [63:0]         out_quot
);

   localparam int STEPS = bptc_pkg::DIV_W;

   typedef struct packed {
      bptc_pkg::side_type side;
      logic               invalid;
      logic               neg;
   } div_tag_type;

   logic [30:0]  rem_ff [0:STEPS];
   logic [63:0]  dq_ff  [0:STEPS];
   logic [30:0]  md_ff  [0:STEPS];
   div_tag_type  tag_ff [0:STEPS];
   logic [STEPS:0] v_ff;

   div_tag_type  tag_in;
   logic [63:0]  dvd_in;
   logic [30:0]  md_in;
   logic [63:0]  quot_ff, quot_in;
   div_tag_type  last_tag_ff;
   logic         last_v_ff;

   // Entry: take magnitudes, remember the quotient sign.
   always_comb begin
      tag_in.side    = in_side;
      tag_in.invalid = (in_den == 31'd0);
      tag_in.neg     = in_num[63] ^ in_den[30];
      dvd_in         = in_num[63] ? (64'd0 - in_num) : in_num;
      md_in          = in_den[30] ? (31'd0 - in_den) : in_den;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= '0;
         dq_ff[0]  <= dvd_in;
         md_ff[0]  <= md_in;
         tag_ff[0] <= tag_in;
      end
   end

   // One quotient bit per stage.
   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [31:0] trial;
      logic [31:0] diff;
      logic        ge;
      logic [30:0] rem_in;

      always_comb begin
         trial  = {rem_ff[k], dq_ff[k][63]};
         diff   = trial - {1'b0, md_ff[k]};
         ge     = (trial >= {1'b0, md_ff[k]});
         rem_in = ge ? diff[30:0] : trial[30:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (adv) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k+1] <= rem_in;
            dq_ff[k+1]  <= {dq_ff[k][62:0], ge};
            md_ff[k+1]  <= md_ff[k];
            tag_ff[k+1] <= tag_ff[k];
         end
      end
   end

   // Exit: restore the sign.
   assign quot_in = tag_ff[STEPS].neg ? (64'd0 - dq_ff[STEPS]) : dq_ff[STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         last_v_ff <= 1'b0;
      end else if (adv) begin
         last_v_ff <= v_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         quot_ff     <= quot_in;
         last_tag_ff <= tag_ff[STEPS];
      end
   end

   assign out_valid   = last_v_ff;
   assign out_side    = last_tag_ff.side;
   assign out_invalid = last_tag_ff.invalid;
   assign out_quot    = quot_ff;

endmodule

`default_nettype wire

### rtl/core/bptc_back.sv
// ---------------------------------------------------------------------------
// Pressure back stages
// Six pipeline stages that apply the quadratic and linear corrections to
// the quotient and form the Q24.8 pressure.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bptc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  bptc_pkg::side_type     in_side,
   input  logic                   in_invalid,
   input  logic [63:0]            in_p,
   input  logic signed [15:0]     p7,
   input  logic signed [15:0]     p8,
   input  logic signed [15:0]     p9,
   output logic                   out_valid,
   output bptc_pkg::out_word_type out_word
);

   logic [5:0] v_ff;
   logic [5:0] v_in;
   bptc_pkg::side_type side_ff [0:5];
   logic [5:0] inv_ff;

   logic [63:0]        ps;
   // Stage 1.
   logic [63:0]        ll_ff, ll_in, pa_ff;
   logic [31:0]        lh_ff, lh_in, phi_ff, phi_in;
   logic signed [48:0] plo_ff, plo_in;
   // Stage 2.
   logic [63:0]        sq_ff, sq_in, y2f_ff, y2f_in, pb_ff;
   // Stage 3.
   logic signed [48:0] qlo_ff, qlo_in;
   logic [31:0]        qhi_ff, qhi_in;
   logic [39:0]        y2a_ff, pc_ff;
   // Stage 4.
   logic [63:0]        y1f;
   logic [39:0]        y1_ff, y2b_ff, pd_ff;
   // Stage 5.
   logic [39:0]        s_ff, s_in;
   // Stage 6.
   logic [31:0]        pres_ff, pres_in;

   // Square from its partial products: low*low plus twice low*high.
   function automatic logic [63:0] ll_in_sum(input logic [63:0] ll, input logic [31:0] lh);
      ll_in_sum = ll + {lh[30:0], 33'd0};
   endfunction

   // Stage arithmetic, everything wraps to 64 bits.
   always_comb begin
      ps      = {{13{in_p[63]}}, in_p[63:13]};
      ll_in   = ps[31:0] * ps[31:0];
      lh_in   = ps[31:0] * ps[63:32];
      plo_in  = $signed({1'b0, in_p[31:0]}) * p8;
      phi_in  = in_p[63:32] * {{16{p8[15]}}, p8};

      sq_in   = ll_in_sum(ll_ff, lh_ff);
      y2f_in  = {{15{plo_ff[48]}}, plo_ff} + {phi_ff, 32'd0};

      qlo_in  = $signed({1'b0, sq_ff[31:0]}) * p9;
      qhi_in  = sq_ff[63:32] * {{16{p9[15]}}, p9};

      y1f     = {{15{qlo_ff[48]}}, qlo_ff} + {qhi_ff, 32'd0};

      s_in    = pd_ff + y1_ff + y2b_ff;
      pres_in = inv_ff[4] ? 32'd0 : (s_ff[39:8] + {{12{p7[15]}}, p7, 4'd0});
      v_in    = {v_ff[4:0], in_valid};
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   // Data registers.
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= in_side;
         for (int i = 1; i < 6; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         inv_ff <= {inv_ff[4:0], in_invalid};
         ll_ff  <= ll_in;
         lh_ff  <= lh_in;
         plo_ff <= plo_in;
         phi_ff <= phi_in;
         pa_ff  <= in_p;
         sq_ff  <= sq_in;
         y2f_ff <= y2f_in;
         pb_ff  <= pa_ff;
         qlo_ff <= qlo_in;
         qhi_ff <= qhi_in;
         y2a_ff <= y2f_ff[58:19];
         pc_ff  <= pb_ff[39:0];
         y1_ff  <= {y1f[63], y1f[63:25]};
         y2b_ff <= y2a_ff;
         pd_ff  <= pc_ff;
         s_ff   <= s_in;
         pres_ff <= pres_in;
      end
   end

   assign out_valid        = v_ff[5];
   assign out_word.invalid = inv_ff[5];
   assign out_word.pres    = pres_ff;
   assign out_word.tf      = side_ff[5].tf;
   assign out_word.tc      = side_ff[5].tc;

endmodule

`default_nettype wire

### rtl/core/baro_temp_pressure_compensation_top.sv
// ---------------------------------------------------------------------------
// Barometric temperature and pressure compensation
// Integer compensation of raw 20-bit temperature and pressure readings with
// calibration coefficients from the register port.
// ---------------------------------------------------------------------------
//  Channel   Dir  Word
//  req_      in   tdata: raw_temperature[19:0], raw_pressure[39:20]
//  rsp_      out  tdata: temperature_centi, fine_temperature, pressure_q24_8;
//                 tuser: pressure_invalid
//  csr_      in   64-bit registers at byte address 8*i
//
//  One reading pair is accepted per cycle while the skid register is empty.
//  The divider computes one quotient bit in each of its 64 stages.
//  Reset is synchronous and clears all valid bits; coefficient registers reset to zero.
//  A stalled result moves into a skid register; the pipeline then holds
//  and req_tready drops until the skid register empties.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module baro_temp_pressure_compensation_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // temperature_centi, fine_temperature, pressure_q24_8
   output logic        rsp_tuser,   // pressure_invalid
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [bptc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bptc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bptc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic        csr_pready
);

   logic [47:0] temp_ff, temp_in;
   logic [63:0] plow_ff, plow_in, phigh_ff, phigh_in;
   logic [15:0] ninth_ff, ninth_in;
   logic        csr_wr;
   bptc_pkg::reg_index_type csr_idx;

   logic adv;

   logic               t_valid;
   bptc_pkg::side_type t_side;
   logic [25:0]        t_x1;
   logic [19:0]        t_raw_p;
   logic               f_valid;
   bptc_pkg::side_type f_side;
   logic [63:0]        f_num;
   logic [30:0]        f_den;
   logic               d_valid;
   bptc_pkg::side_type d_side;
   logic               d_invalid;
   logic [63:0]        d_quot;
   logic               b_valid;
   bptc_pkg::out_word_type b_word;

   logic                   out_v_ff, out_v_in, skid_v_ff, skid_v_in;
   bptc_pkg::out_word_type out_d_ff, out_d_in, skid_d_ff, skid_d_in;

   // Register port.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = bptc_pkg::reg_index_type'(csr_paddr[4:3]);

   always_comb begin
      temp_in  = temp_ff;
      plow_in  = plow_ff;
      phigh_in = phigh_ff;
      ninth_in = ninth_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            bptc_pkg::REG_TEMP_COEFFS: temp_in  = csr_pwdata[47:0];
            bptc_pkg::REG_PRESS_LOW:   plow_in  = csr_pwdata;
            bptc_pkg::REG_PRESS_HIGH:  phigh_in = csr_pwdata;
            bptc_pkg::REG_PRESS_NINTH: ninth_in = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff  <= '0;
         plow_ff  <= '0;
         phigh_ff <= '0;
         ninth_ff <= '0;
      end else begin
         temp_ff  <= temp_in;
         plow_ff  <= plow_in;
         phigh_ff <= phigh_in;
         ninth_ff <= ninth_in;
      end
   end

   always_comb begin
      unique case (csr_idx)
         bptc_pkg::REG_TEMP_COEFFS: csr_prdata = {16'd0, temp_ff};
         bptc_pkg::REG_PRESS_LOW:   csr_prdata = plow_ff;
         bptc_pkg::REG_PRESS_HIGH:  csr_prdata = phigh_ff;
         bptc_pkg::REG_PRESS_NINTH: csr_prdata = {48'd0, ninth_ff};
         default:                   csr_prdata = '0;
      endcase
   end

   // The whole pipeline moves while the skid register is free.
   assign adv        = ~skid_v_ff;
   assign req_tready = adv;

   bptc_temp u_temp (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .raw_t     (req_tdata[19:0]),
      .raw_p     (req_tdata[39:20]),
      .t1        (temp_ff[15:0]),
      .t2        (temp_ff[31:16]),
      .t3        (temp_ff[47:32]),
      .out_valid (t_valid),
      .out_side  (t_side),
      .out_x1    (t_x1),
      .out_raw_p (t_raw_p)
   );

   bptc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (t_valid),
      .in_side   (t_side),
      .in_x1     (t_x1),
      .in_raw_p  (t_raw_p),
      .p1        (plow_ff[15:0]),
      .p2        (plow_ff[31:16]),
      .p3        (plow_ff[47:32]),
      .p4        (plow_ff[63:48]),
      .p5        (phigh_ff[15:0]),
      .p6        (phigh_ff[31:16]),
      .out_valid (f_valid),
      .out_side  (f_side),
      .out_num   (f_num),
      .out_den   (f_den)
   );

   bptc_sdiv u_sdiv (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (f_valid),
      .in_side     (f_side),
      .in_num      (f_num),
      .in_den      (f_den),
      .out_valid   (d_valid),
      .out_side    (d_side),
      .out_invalid (d_invalid),
      .out_quot    (d_quot)
   );

   bptc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (d_valid),
      .in_side    (d_side),
      .in_invalid (d_invalid),
      .in_p       (d_quot),
      .p7         (phigh_ff[47:32]),
      .p8         (phigh_ff[63:48]),
      .p9         (ninth_ff),
      .out_valid  (b_valid),
      .out_word   (b_word)
   );

   // Output register with a skid register behind it.
   always_comb begin
      out_v_in  = out_v_ff;
      out_d_in  = out_d_ff;
      skid_v_in = skid_v_ff;
      skid_d_in = skid_d_ff;
      if (out_v_ff && rsp_tready) begin
         out_v_in = 1'b0;
      end
      if (skid_v_ff && !out_v_in) begin
         out_v_in  = 1'b1;
         out_d_in  = skid_d_ff;
         skid_v_in = 1'b0;
      end
      if (b_valid && adv) begin
         if (!out_v_in) begin
            out_v_in = 1'b1;
            out_d_in = b_word;
         end else begin
            skid_v_in = 1'b1;
            skid_d_in = b_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_d_ff  <= out_d_in;
      skid_d_ff <= skid_d_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff[95:0];
   assign rsp_tuser  = out_d_ff.invalid;

endmodule

`default_nettype wire

### rtl/core/bptc_checker.sv
// ---------------------------------------------------------------------------
// Compensation port checker
// Checks on the top-level ports, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bptc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic        rsp_tuser
);

   logic signed [39:0] tf_x;
   logic signed [39:0] tc_exp;

   // Centidegree temperature follows from the fine temperature.
   assign tf_x   = {{8{rsp_tdata[63]}}, rsp_tdata[63:32]};
   assign tc_exp = (tf_x * 40'sd5 + 40'sd128) >>> 8;

   // A stalled word holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   // An invalid pressure reads as zero.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[95:64] == 32'd0)
      else $error("invalid pressure is not zero");

   // Nothing is presented right after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Temperature pair is consistent.
   a_temp_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:0] == tc_exp[31:0])
      else $error("temperature does not match fine temperature");

endmodule

bind baro_temp_pressure_compensation_top bptc_checker u_bptc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

### test/baro_temp_pressure_compensation_top_test.sv
// ---------------------------------------------------------------------------
// Barometric compensation testbench
// Streams raw temperature and pressure word pairs through the compensation
// core under several coefficient settings and idle patterns, and checks each
// result word against an integer compensation computed in the bench.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module baro_temp_pressure_compensation_top_test;

   localparam int LATENCY = 84;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [31:0] tc;
      logic [31:0] tf;
      logic [31:0] pres;
      logic        invalid;
   } comp_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [bptc_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [bptc_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [bptc_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic        csr_pready;

   baro_temp_pressure_compensation_top dut (.*);

   always #2 clock = ~clock;

   // Shadow copy of the coefficient registers.
   logic [47:0] coef_temp = '0;
   logic [63:0] coef_press_low = '0;
   logic [63:0] coef_press_high = '0;
   logic [15:0] coef_ninth = '0;

   logic [39:0]     word_queue[$];
   comp_result_type expected_results[$];
   int  error_count = 0;
   int  result_count = 0;
   int  invalid_count = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  sender_hold = 1'b0;
   bit  stimulus_done = 1'b0;
   int  quiet_cycles = 0;

   function automatic logic signed [63:0] sext16(logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   // Integer compensation with 64-bit wrapping arithmetic.
   function automatic comp_result_type compensate(logic [19:0] at, logic [19:0] ap);
      comp_result_type r;
      logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic signed [63:0] d1, v1, d2, v2, tf, tc, x1, x2, p, ps, y1, y2, num;
      logic signed [63:0] at64, ap64;
      logic [63:0] mn, md, q;
      at64 = {44'd0, at};
      ap64 = {44'd0, ap};
      t1 = {48'd0, coef_temp[15:0]};
      t2 = sext16(coef_temp[31:16]);
      t3 = sext16(coef_temp[47:32]);
      p1 = {48'd0, coef_press_low[15:0]};
      p2 = sext16(coef_press_low[31:16]);
      p3 = sext16(coef_press_low[47:32]);
      p4 = sext16(coef_press_low[63:48]);
      p5 = sext16(coef_press_high[15:0]);
      p6 = sext16(coef_press_high[31:16]);
      p7 = sext16(coef_press_high[47:32]);
      p8 = sext16(coef_press_high[63:48]);
      p9 = sext16(coef_ninth);
      d1 = (at64 >>> 3) - (t1 <<< 1);
      v1 = (d1 * t2) >>> 11;
      d2 = (at64 >>> 4) - t1;
      v2 = (((d2 * d2) >>> 12) * t3) >>> 14;
      tf = v1 + v2;
      tf = {{32{tf[31]}}, tf[31:0]};
      tc = (tf * 64'sd5 + 64'sd128) >>> 8;
      x1 = tf - 64'sd128000;
      x2 = x1 * x1 * p6;
      x2 = x2 + ((x1 * p5) <<< 17);
      x2 = x2 + (p4 <<< 35);
      x1 = ((x1 * x1 * p3) >>> 8) + ((x1 * p2) <<< 12);
      x1 = (((64'sd1 <<< 47) + x1) * p1) >>> 33;
      r.tc = tc[31:0];
      r.tf = tf[31:0];
      r.pres = '0;
      r.invalid = 1'b1;
      if (x1 != 0) begin
         p = 64'sd1048576 - ap64;
         num = ((p <<< 31) - x2) * 64'sd3125;
         mn = num[63] ? -num : num;
         md = x1[63] ? -x1 : x1;
         q = mn / md;
         p = (num[63] != x1[63]) ? -q : q;
         ps = p >>> 13;
         y1 = (p9 * ps * ps) >>> 25;
         y2 = (p8 * p) >>> 19;
         p = ((p + y1 + y2) >>> 8) + (p7 <<< 4);
         r.pres = p[31:0];
         r.invalid = 1'b0;
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s at result %0d: got %h, want %h", what, result_count, got, want);
      error_count++;
   endtask

   // Driver: presents words from the queue, idling at random.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (word_queue.size() > 0 && !sender_hold &&
             $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= word_queue.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Predict on acceptance.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         expected_results.push_back(compensate(req_tdata[19:0], req_tdata[39:20]));
   end

   // Monitor: compares each accepted result word with the oldest expectation.
   always @(posedge clock) begin
      comp_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result word", rsp_tdata[63:0], 64'd0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[31:0] !== want.tc)
                  report_mismatch("temperature_centi", 64'(rsp_tdata[31:0]), 64'(want.tc));
               if (rsp_tdata[63:32] !== want.tf)
                  report_mismatch("fine_temperature", 64'(rsp_tdata[63:32]), 64'(want.tf));
               if (rsp_tdata[95:64] !== want.pres)
                  report_mismatch("pressure_q24_8", 64'(rsp_tdata[95:64]), 64'(want.pres));
               if (rsp_tuser !== want.invalid)
                  report_mismatch("pressure_invalid", 64'(rsp_tuser), 64'(want.invalid));
               if (want.invalid)
                  invalid_count++;
            end
            result_count++;
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog on cycles without any accepted word.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || stimulus_done)
         quiet_cycles <= 0;
      else if (word_queue.size() > 0 || expected_results.size() > 0 || req_tvalid)
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d results outstanding", expected_results.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic csr_write(bptc_pkg::reg_index_type idx, logic [63:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      unique case (idx)
         bptc_pkg::REG_TEMP_COEFFS: coef_temp       = value[47:0];
         bptc_pkg::REG_PRESS_LOW:   coef_press_low  = value;
         bptc_pkg::REG_PRESS_HIGH:  coef_press_high = value;
         bptc_pkg::REG_PRESS_NINTH: coef_ninth      = value[15:0];
      endcase
   endtask

   task automatic wait_drained();
      while (word_queue.size() > 0 || req_tvalid || expected_results.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   // A typical coefficient set, extreme sets, or random values (p1 cleared in mode 4).
   task automatic load_coefficients(int mode);
      logic [63:0] rt, rl, rh, r9;
      rt = {$urandom, $urandom};
      rl = {$urandom, $urandom};
      rh = {$urandom, $urandom};
      r9 = {$urandom, $urandom};
      case (mode)
         0: begin
            csr_write(bptc_pkg::REG_TEMP_COEFFS,
                      {16'hFFFF, 16'd50, 16'sd26435, 16'd27504});
            csr_write(bptc_pkg::REG_PRESS_LOW, {16'd2855, 16'hD5D0, 16'h2BC6, 16'd36477});
            csr_write(bptc_pkg::REG_PRESS_HIGH, {16'hBFF0, 16'd15500, 16'hFFF9, 16'd140});
            csr_write(bptc_pkg::REG_PRESS_NINTH, 64'd6000);
         end
         1: begin
            csr_write(bptc_pkg::REG_TEMP_COEFFS, {16'h0, 16'h7FFF, 16'h7FFF, 16'hFFFF});
            csr_write(bptc_pkg::REG_PRESS_LOW, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF});
            csr_write(bptc_pkg::REG_PRESS_HIGH, 64'h7FFF_7FFF_7FFF_7FFF);
            csr_write(bptc_pkg::REG_PRESS_NINTH, 64'h7FFF);
         end
         2: begin
            csr_write(bptc_pkg::REG_TEMP_COEFFS, {rt[63:48], 16'h8000, 16'h8000, 16'h0000});
            csr_write(bptc_pkg::REG_PRESS_LOW, 64'h8000_8000_8000_0001);
            csr_write(bptc_pkg::REG_PRESS_HIGH, 64'h8000_8000_8000_8000);
            csr_write(bptc_pkg::REG_PRESS_NINTH, {r9[63:16], 16'h8000});
         end
         default: begin
            csr_write(bptc_pkg::REG_TEMP_COEFFS, rt);
            csr_write(bptc_pkg::REG_PRESS_LOW, (mode == 4) ? {rl[63:16], 16'h0} : rl);
            csr_write(bptc_pkg::REG_PRESS_HIGH, rh);
            csr_write(bptc_pkg::REG_PRESS_NINTH, r9);
         end
      endcase
   endtask

   function automatic logic [19:0] pick_raw();
      case ($urandom_range(9))
         0: return 20'h00000;
         1: return 20'hFFFFF;
         2: return 20'h80000 + 20'($urandom_range(4095));
         default: return 20'($urandom);
      endcase
   endfunction

   initial begin
      int idle_sets[4][2];
      idle_sets = '{'{0, 0}, '{49, 0}, '{0, 49}, '{7, 7}};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed words under zero coefficients, then typical ones.
      for (int m = 0; m < 2; m++) begin
         if (m == 1) load_coefficients(0);
         word_queue.push_back({20'h00000, 20'h00000});
         word_queue.push_back({20'hFFFFF, 20'hFFFFF});
         word_queue.push_back({20'h00000, 20'hFFFFF});
         word_queue.push_back({20'hFFFFF, 20'h00000});
         word_queue.push_back({20'h6E380, 20'h7EED0});
         word_queue.push_back({20'hAAAAA, 20'h55555});
         wait_drained();
      end

      // Random phases across coefficient modes and idle patterns.
      for (int ph = 0; ph < 12; ph++) begin
         send_idle_pct  = idle_sets[ph % 4][0];
         recv_stall_pct = idle_sets[ph % 4][1];
         load_coefficients(ph % 5);
         for (int i = 0; i < 100; i++)
            word_queue.push_back({pick_raw(), pick_raw()});
         if (ph == 5) begin
            // Sender holds off mid-phase until all results are back.
            while (word_queue.size() > 50) @(posedge clock);
            sender_hold = 1'b1;
            while (req_tvalid || expected_results.size() > 0) @(posedge clock);
            sender_hold = 1'b0;
         end
         wait_drained();
      end

      stimulus_done = 1'b1;
      $display("Covered %0d results (%0d with zero divisor) over 14 coefficient phases",
               result_count, invalid_count);
      $display("and four idle and stall patterns.");
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/bptc_pkg.sv
rtl/core/bptc_temp.sv
rtl/core/bptc_front.sv
rtl/core/bptc_sdiv.sv
rtl/core/bptc_back.sv
rtl/core/baro_temp_pressure_compensation_top.sv
rtl/core/bptc_checker.sv
test/baro_temp_pressure_compensation_top_test.sv
